// ===== rtl/core/polyline_box_extruder_macros.svh =====
// Assertion macros for the polyline box extruder.
`ifndef POLYLINE_BOX_EXTRUDER_MACROS_SVH
`define POLYLINE_BOX_EXTRUDER_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define PBE_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");
// Condition that must never hold.
`define PBE_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PBE_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define PBE_ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

// ===== rtl/core/pbe_pkg.sv =====
package pbe_pkg;

  localparam int MAX_SEGMENTS    = 4096;
  localparam int COORD_FRAC_BITS = 16;
  localparam int SEG_W           = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W           = 15;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = 1;
  localparam int LAST_RESULT     = 19;
  localparam int LAST_CORNER     = 7;

  localparam logic [31:0] LINE_WIDTH_RESET = 32'(64'd1 << COORD_FRAC_BITS);

  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] delta_t;

  // One segment handed from front to back
  typedef struct packed {
    coord_t [2:0]      start_pt;
    coord_t [2:0]      end_pt;
    delta_t [2:0]      delta;
    logic [2:0][30:0]  half_ext;
    logic [IDX_W-1:0]  base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQUARE, N_SQRT, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIR_GO, B_DIR_WAIT, B_RIGHT_GO, B_RIGHT_WAIT,
    B_CROSS_A, B_CROSS_B, B_UP_GO, B_UP_WAIT, B_MUL, B_EMIT
  } back_state_t;

  localparam logic [2:0] TRI_TABLE [0:35] = '{
    3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3,
    3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd7,
    3'd0, 3'd4, 3'd1, 3'd1, 3'd4, 3'd5,
    3'd2, 3'd6, 3'd3, 3'd3, 3'd6, 3'd7,
    3'd0, 3'd3, 3'd4, 3'd3, 3'd4, 3'd7,
    3'd1, 3'd5, 3'd2, 3'd2, 3'd5, 3'd6
  };

  // Local corner number of vertex j of triangle t
  function automatic logic [2:0] tri_corner(input logic [3:0] t, input logic [1:0] j);
    logic [5:0] idx;
    idx = 6'(t) * 6'd3 + 6'(j);
    return TRI_TABLE[idx];
  endfunction

endpackage

// ===== rtl/core/pbe_front.sv =====
module pbe_front import pbe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [31:0]  line_width,
  input  logic         point_valid,
  output logic         point_ready,
  input  logic         first_point,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  q_status_t    qs,
  output logic         push,
  output job_t         push_job
);

  coord_t           prev [3];
  coord_t           bmin [3];
  coord_t           bmax [3];
  logic             have_prev;
  logic [SEG_W-1:0] seg_count;

  coord_t           pt [3];
  coord_t           nmin [3];
  coord_t           nmax [3];
  logic             accept;
  logic             restart;
  logic             seg_full;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  assign point_ready = !qs.full;
  assign accept      = point_valid && point_ready;
  assign restart     = first_point || !have_prev;
  assign seg_full    = seg_count >= SEG_W'(MAX_SEGMENTS);
  assign push        = accept && !restart && !seg_full;

  // Bounds update, half extents and segment delta
  always_comb begin
    logic signed [33:0] span;
    logic [32:0]        half;
    for (int i = 0; i < 3; i++) begin
      nmin[i] = (pt[i] < bmin[i]) ? pt[i] : bmin[i];
      nmax[i] = (pt[i] > bmax[i]) ? pt[i] : bmax[i];
      span = 34'(nmax[i]) - 34'(nmin[i]) + $signed({2'b00, line_width});
      half = 33'(span >>> 1);
      push_job.half_ext[i] = (half[32:31] != 2'b00) ? 31'h7FFF_FFFF : half[30:0];
      push_job.start_pt[i] = prev[i];
      push_job.end_pt[i]   = pt[i];
      push_job.delta[i]    = 33'(pt[i]) - 33'(prev[i]);
    end
    push_job.base = {seg_count[IDX_W-4:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      seg_count <= '0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
        bmin[i] <= '0;
        bmax[i] <= '0;
      end
    end else if (accept) begin
      if (restart) begin
        have_prev <= 1'b1;
        seg_count <= '0;
        for (int i = 0; i < 3; i++) begin
          prev[i] <= pt[i];
          bmin[i] <= pt[i];
          bmax[i] <= pt[i];
        end
      end else if (!seg_full) begin
        seg_count <= seg_count + SEG_W'(1);
        for (int i = 0; i < 3; i++) begin
          prev[i] <= pt[i];
          bmin[i] <= nmin[i];
          bmax[i] <= nmax[i];
        end
      end
    end
  end

endmodule

// ===== rtl/core/pbe_queue.sv =====
module pbe_queue import pbe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      pop_job,
  output q_status_t qs
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign pop_job  = mem[rptr];
  assign qs.full  = count == (QPTR_W+1)'(QDEPTH);
  assign qs.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      if (pop)  rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      if (push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

endmodule

// ===== rtl/core/pbe_norm.sv =====
module pbe_norm import pbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] vec_in [3],
  output logic               done,
  output logic signed [31:0] unit_out [3]
);

  norm_state_t state, state_next;
  logic [63:0] m [3];
  logic        neg [3];
  logic [63:0] sum;
  logic [63:0] sq_n;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [32:0] rem [3];
  logic [30:0] quo [3];
  logic [4:0]  cnt;

  logic [63:0] mx;
  logic        all_zero;
  logic [63:0] sum_add;
  logic [63:0] trial;

  assign mx = (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                            : ((m[1] > m[2]) ? m[1] : m[2]);
  assign all_zero = (vec_in[0] == '0) && (vec_in[1] == '0) && (vec_in[2] == '0);
  assign sum_add  = sum + 64'(m[cnt[1:0]][30:0] * m[cnt[1:0]][30:0]);
  assign trial    = sq_res + sq_bit;
  assign done     = state == N_DONE;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_out[i] = neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:   if (start) state_next = all_zero ? N_DONE : N_SCALE;
      N_SCALE:  if (mx[63:31] == '0 && mx[30]) state_next = N_SQUARE;
      N_SQUARE: if (cnt == 5'd2) state_next = N_SQRT;
      N_SQRT:   if (cnt == 5'd31) state_next = N_DIV;
      N_DIV:    if (cnt == 5'd30) state_next = N_DONE;
      N_DONE:   state_next = N_IDLE;
      default:  state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= N_IDLE;
    else     state <= state_next;
  end

  // Datapath: scale, sum of squares, square root, three-lane division
  always_ff @(posedge clk) begin
    logic [32:0] sh;
    unique case (state)
      N_IDLE: begin
        cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          m[i]   <= vec_in[i][63] ? 64'(-vec_in[i]) : 64'(vec_in[i]);
          neg[i] <= vec_in[i][63];
          quo[i] <= '0;
        end
      end
      N_SCALE: begin
        sum <= '0;
        for (int i = 0; i < 3; i++) begin
          if (mx[63:39] != '0)       m[i] <= m[i] >> 8;
          else if (mx[63:31] != '0)  m[i] <= m[i] >> 1;
          else if (mx[63:22] == '0)  m[i] <= m[i] << 8;
          else if (!mx[30])          m[i] <= m[i] << 1;
        end
      end
      N_SQUARE: begin
        sum <= sum_add;
        if (cnt == 5'd2) begin
          sq_n   <= sum_add;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          cnt    <= '0;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      N_SQRT: begin
        if (sq_n >= trial) begin
          sq_n   <= sq_n - trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (cnt == 5'd31) begin
          cnt <= '0;
          for (int i = 0; i < 3; i++) rem[i] <= 33'(m[i][30:1]);
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      N_DIV: begin
        cnt <= cnt + 5'd1;
        for (int i = 0; i < 3; i++) begin
          sh = {rem[i][31:0], (cnt == '0) ? m[i][0] : 1'b0};
          if (sh >= {1'b0, sq_res[31:0]}) begin
            rem[i] <= sh - {1'b0, sq_res[31:0]};
            quo[i] <= {quo[i][29:0], 1'b1};
          end else begin
            rem[i] <= sh;
            quo[i] <= {quo[i][29:0], 1'b0};
          end
        end
      end
      N_DONE: cnt <= '0;
      default: cnt <= '0;
    endcase
  end

endmodule

// ===== rtl/core/pbe_back.sv =====
module pbe_back import pbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        line_width,
  input  q_status_t          qs,
  input  job_t               pop_job,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               result_kind,
  output logic signed [31:0] corner_x,
  output logic signed [31:0] corner_y,
  output logic signed [31:0] corner_z,
  output logic [14:0]        tri_first,
  output logic [14:0]        tri_second,
  output logic [14:0]        tri_third,
  output logic [30:0]        half_extent_x,
  output logic [30:0]        half_extent_y,
  output logic [30:0]        half_extent_z,
  output logic               last_of_segment
);

  back_state_t state, state_next;
  job_t        job;
  coord_t      dir [3];
  coord_t      rgt [3];
  coord_t      up [3];
  logic signed [63:0] prod_a [3];
  logic signed [63:0] prod_b [3];
  logic        cneg [3];
  logic [4:0]  k;

  logic               norm_start;
  logic               norm_done;
  logic signed [63:0] norm_vec [3];
  logic signed [31:0] norm_unit [3];
  logic               out_load;
  logic               rzero;
  logic [3:0]         tidx;
  coord_t             corner [3];
  logic [IDX_W-1:0]   tri_idx [3];

  pbe_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (norm_start),
    .vec_in   (norm_vec),
    .done     (norm_done),
    .unit_out (norm_unit)
  );

  assign out_load   = !result_valid || result_ready;
  assign norm_start = (state == B_DIR_GO) || (state == B_RIGHT_GO) || (state == B_UP_GO);
  assign pop        = (state == B_IDLE) && !qs.empty;
  assign rzero      = (dir[2] == '0) && (dir[0] == '0);
  assign tidx       = 4'(k - 5'd8);

  // Vector fed to the normalizer
  always_comb begin
    priority case (state)
      B_DIR_GO: for (int i = 0; i < 3; i++) norm_vec[i] = 64'(job.delta[i]);
      B_RIGHT_GO: begin
        if (rzero) begin
          norm_vec[0] = '0;
          norm_vec[1] = 64'(dir[2]);
          norm_vec[2] = -64'(dir[1]);
        end else begin
          norm_vec[0] = -64'(dir[2]);
          norm_vec[1] = '0;
          norm_vec[2] = 64'(dir[0]);
        end
      end
      default: for (int i = 0; i < 3; i++) norm_vec[i] = prod_a[i] - prod_b[i];
    endcase
  end

  // Corner position and triangle indices for result k
  always_comb begin
    logic [32:0]        mag;
    logic signed [34:0] off;
    logic signed [34:0] sum;
    for (int i = 0; i < 3; i++) begin
      mag = 33'((64'(prod_a[i]) + (64'd1 << 30)) >> 31);
      off = cneg[i] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      sum = 35'(k[2] ? job.end_pt[i] : job.start_pt[i]) + off;
      if (sum > 35'sh0_7FFF_FFFF)       corner[i] = 32'sh7FFF_FFFF;
      else if (sum < -35'sh0_8000_0000) corner[i] = 32'sh8000_0000;
      else                              corner[i] = sum[31:0];
      tri_idx[i] = job.base + IDX_W'(tri_corner(tidx, 2'(i)));
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:       if (!qs.empty) state_next = B_DIR_GO;
      B_DIR_GO:     state_next = B_DIR_WAIT;
      B_DIR_WAIT:   if (norm_done) state_next = B_RIGHT_GO;
      B_RIGHT_GO:   state_next = B_RIGHT_WAIT;
      B_RIGHT_WAIT: if (norm_done) state_next = B_CROSS_A;
      B_CROSS_A:    state_next = B_CROSS_B;
      B_CROSS_B:    state_next = B_UP_GO;
      B_UP_GO:      state_next = B_UP_WAIT;
      B_UP_WAIT:    if (norm_done) state_next = B_MUL;
      B_MUL:        state_next = B_EMIT;
      B_EMIT: begin
        if (out_load) begin
          if (k == 5'(LAST_RESULT))      state_next = B_IDLE;
          else if (k < 5'(LAST_CORNER))  state_next = B_MUL;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Frame and corner datapath
  always_ff @(posedge clk) begin
    logic signed [33:0] combo;
    if (pop) job <= pop_job;
    unique case (state)
      B_DIR_WAIT:   if (norm_done) for (int i = 0; i < 3; i++) dir[i] <= norm_unit[i];
      B_RIGHT_WAIT: if (norm_done) for (int i = 0; i < 3; i++) rgt[i] <= norm_unit[i];
      B_CROSS_A: begin
        prod_a[0] <= rgt[1] * dir[2];
        prod_a[1] <= rgt[2] * dir[0];
        prod_a[2] <= rgt[0] * dir[1];
      end
      B_CROSS_B: begin
        prod_b[0] <= rgt[2] * dir[1];
        prod_b[1] <= rgt[0] * dir[2];
        prod_b[2] <= rgt[1] * dir[0];
      end
      B_UP_WAIT: begin
        k <= '0;
        if (norm_done) for (int i = 0; i < 3; i++) up[i] <= norm_unit[i];
      end
      B_MUL: begin
        for (int i = 0; i < 3; i++) begin
          combo = (k[1] ? -34'(up[i]) : 34'(up[i]))
                + ((k[1:0] == 2'd1 || k[1:0] == 2'd2) ? -34'(rgt[i]) : 34'(rgt[i]));
          cneg[i]   <= combo[33];
          prod_a[i] <= $signed(64'(32'(combo[33] ? -combo : combo)) * 64'(line_width));
        end
      end
      B_EMIT: if (out_load) k <= k + 5'd1;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= state == B_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && state == B_EMIT) begin
      half_extent_x   <= job.half_ext[0];
      half_extent_y   <= job.half_ext[1];
      half_extent_z   <= job.half_ext[2];
      last_of_segment <= k == 5'(LAST_RESULT);
      if (k <= 5'(LAST_CORNER)) begin
        result_kind <= KIND_CORNER;
        corner_x    <= corner[0];
        corner_y    <= corner[1];
        corner_z    <= corner[2];
        tri_first   <= '0;
        tri_second  <= '0;
        tri_third   <= '0;
      end else begin
        result_kind <= KIND_TRI;
        corner_x    <= '0;
        corner_y    <= '0;
        corner_z    <= '0;
        tri_first   <= tri_idx[0];
        tri_second  <= tri_idx[1];
        tri_third   <= tri_idx[2];
      end
    end
  end

endmodule

// ===== rtl/core/polyline_box_extruder.sv =====
// Polyline box extruder: takes one Q16.16 point per request and, for every
// point after the first of a polyline, emits twenty results for the segment
// from the previous point: eight box corners (start end first) then twelve
// triangles whose indices advance by eight per segment. A point that starts a
// polyline, or arrives once the segment limit is reached, is taken and yields
// nothing. A segment point is classified by the front end and queued (two
// deep); the back end then runs the shared normalization unit three times
// (direction, right, up), each pass scaling, summing squares, taking a square
// root and dividing, and then passes each corner through a multiply step
// before emitting it, while triangles are emitted directly. A zero-length
// segment has null vectors, so each pass goes straight to done. A low
// result_ready stalls the output. The user must write line_width only while
// the block is idle; the block itself does not enforce this.
`include "polyline_box_extruder_macros.svh"

module polyline_box_extruder import pbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               line_width_we,
  input  logic [31:0]        line_width_data,
  input  logic               point_valid,
  output logic               point_ready,
  input  logic               first_point,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               result_kind,
  output logic signed [31:0] corner_x,
  output logic signed [31:0] corner_y,
  output logic signed [31:0] corner_z,
  output logic [14:0]        tri_first,
  output logic [14:0]        tri_second,
  output logic [14:0]        tri_third,
  output logic [30:0]        half_extent_x,
  output logic [30:0]        half_extent_y,
  output logic [30:0]        half_extent_z,
  output logic               last_of_segment
);

  logic [31:0] line_width;
  q_status_t   qs;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        pop_job;
  logic        last_out;
  logic        corner_out;
  logic        idx_zero;

  // Width register
  always_ff @(posedge clk) begin
    if (rst)                line_width <= LINE_WIDTH_RESET;
    else if (line_width_we) line_width <= line_width_data;
  end

  pbe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .line_width  (line_width),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .first_point (first_point),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .qs          (qs),
    .push        (push),
    .push_job    (push_job)
  );

  pbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qs       (qs)
  );

  pbe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .line_width      (line_width),
    .qs              (qs),
    .pop_job         (pop_job),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_kind     (result_kind),
    .corner_x        (corner_x),
    .corner_y        (corner_y),
    .corner_z        (corner_z),
    .tri_first       (tri_first),
    .tri_second      (tri_second),
    .tri_third       (tri_third),
    .half_extent_x   (half_extent_x),
    .half_extent_y   (half_extent_y),
    .half_extent_z   (half_extent_z),
    .last_of_segment (last_of_segment)
  );

  // Checks
  assign last_out   = result_valid && last_of_segment;
  assign corner_out = result_valid && (result_kind == KIND_CORNER);
  assign idx_zero   = (tri_first == '0) && (tri_second == '0) && (tri_third == '0);

  `PBE_ASSERT_NEVER(a_queue_state, clk, rst, qs.full && qs.empty)
  `PBE_ASSERT_NEVER(a_push_when_full, clk, rst, push && qs.full && !pop)
  `PBE_ASSERT_IMPLY(a_last_is_tri, clk, rst, last_out, result_kind == KIND_TRI)
  `PBE_ASSERT_IMPLY(a_corner_no_idx, clk, rst, corner_out, idx_zero)

endmodule

// ===== verif/polyline_box_checker.sv =====
// Watches the point and result channels, predicts each segment's twenty
// results and compares them field by field.
module polyline_box_checker import pbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               line_width_we,
  input  logic [31:0]        line_width_data,
  input  logic               point_valid,
  input  logic               point_ready,
  input  logic               first_point,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic               result_kind,
  input  logic signed [31:0] corner_x,
  input  logic signed [31:0] corner_y,
  input  logic signed [31:0] corner_z,
  input  logic [14:0]        tri_first,
  input  logic [14:0]        tri_second,
  input  logic [14:0]        tri_third,
  input  logic [30:0]        half_extent_x,
  input  logic [30:0]        half_extent_y,
  input  logic [30:0]        half_extent_z,
  input  logic               last_of_segment,
  output int                 errors,
  output int                 pending,
  output int                 segments_seen
);

  typedef struct packed {
    logic              kind;
    logic [2:0][31:0]  corner;
    logic [2:0][14:0]  tri_idx;
    logic [2:0][30:0]  half_ext;
    logic              last;
  } box_result_t;

  box_result_t expected_q[$];

  logic [31:0]        width_q;
  logic signed [31:0] prev_pt[3];
  logic signed [31:0] bmin[3];
  logic signed [31:0] bmax[3];
  logic               have_prev;
  int unsigned        seg_cnt;

  assign pending = expected_q.size();

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale to [2^30, 2^31), then divide by the integer length into Q1.30
  task automatic normalize(input longint v[3], output int u[3]);
    logic [63:0] m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << 30) / len;
      u[i] = v[i] < 0 ? -int'(q[31:0]) : int'(q[31:0]);
    end
  endtask

  function automatic longint width_offset(input longint combo, input logic [31:0] w);
    logic [63:0] p;
    longint o;
    p = mag(combo) * 64'(w);
    o = longint'((p + (64'd1 << 30)) >> 31);
    return combo < 0 ? -o : o;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Builds the frame and queues a segment's corners and triangles
  task automatic extrude_point(input logic fp, input logic signed [31:0] px,
                               input logic signed [31:0] py,
                               input logic signed [31:0] pz);
    logic signed [31:0] p[3];
    longint v[3], he[3], combo;
    int dir[3], rgt[3], up[3];
    int su, sr;
    box_result_t r;
    p[0] = px; p[1] = py; p[2] = pz;
    if (fp || !have_prev) begin
      for (int i = 0; i < 3; i++) begin
        prev_pt[i] = p[i]; bmin[i] = p[i]; bmax[i] = p[i];
      end
      have_prev = 1;
      seg_cnt = 0;
      return;
    end
    if (seg_cnt >= MAX_SEGMENTS) return;
    for (int i = 0; i < 3; i++) begin
      if (p[i] < bmin[i]) bmin[i] = p[i];
      if (p[i] > bmax[i]) bmax[i] = p[i];
      he[i] = (longint'(bmax[i]) - longint'(bmin[i]) + longint'(width_q)) >>> 1;
      if (he[i] > 64'sh7fffffff) he[i] = 64'sh7fffffff;
      v[i] = longint'(p[i]) - longint'(prev_pt[i]);
    end
    normalize(v, dir);
    v[0] = -longint'(dir[2]); v[1] = 0; v[2] = dir[0];
    // vertical direction: fall back to the Z axis
    if (v[0] == 0 && v[2] == 0) begin
      v[1] = dir[2]; v[2] = -longint'(dir[1]);
    end
    normalize(v, rgt);
    v[0] = longint'(rgt[1]) * dir[2] - longint'(rgt[2]) * dir[1];
    v[1] = longint'(rgt[2]) * dir[0] - longint'(rgt[0]) * dir[2];
    v[2] = longint'(rgt[0]) * dir[1] - longint'(rgt[1]) * dir[0];
    normalize(v, up);
    for (int k = 0; k < 20; k++) begin
      r = '0;
      for (int i = 0; i < 3; i++) r.half_ext[i] = he[i][30:0];
      r.last = (k == LAST_RESULT);
      if (k <= LAST_CORNER) begin
        r.kind = KIND_CORNER;
        su = ((k & 3) < 2) ? 1 : -1;
        sr = ((k & 3) == 0 || (k & 3) == 3) ? 1 : -1;
        for (int i = 0; i < 3; i++) begin
          combo = longint'(su) * up[i] + longint'(sr) * rgt[i];
          r.corner[i] = clamp32((k < 4 ? longint'(prev_pt[i]) : longint'(p[i]))
                                + width_offset(combo, width_q));
        end
      end else begin
        r.kind = KIND_TRI;
        for (int j = 0; j < 3; j++)
          r.tri_idx[j] = 15'(seg_cnt * 8 + TRI_TABLE[(k - 8) * 3 + j]);
      end
      expected_q.push_back(r);
    end
    for (int i = 0; i < 3; i++) prev_pt[i] = p[i];
    seg_cnt++;
  endtask

  box_result_t got, exp_r;

  always_comb begin
    got.kind = result_kind;
    got.corner[0] = corner_x;
    got.corner[1] = corner_y;
    got.corner[2] = corner_z;
    got.tri_idx[0] = tri_first;
    got.tri_idx[1] = tri_second;
    got.tri_idx[2] = tri_third;
    got.half_ext[0] = half_extent_x;
    got.half_ext[1] = half_extent_y;
    got.half_ext[2] = half_extent_z;
    got.last = last_of_segment;
  end

  always @(posedge clk) begin
    if (rst) begin
      width_q <= LINE_WIDTH_RESET;
      have_prev = 0;
      seg_cnt = 0;
      for (int i = 0; i < 3; i++) begin
        prev_pt[i] = 0; bmin[i] = 0; bmax[i] = 0;
      end
      expected_q.delete();
      errors <= 0;
      segments_seen <= 0;
    end else begin
      if (line_width_we) width_q <= line_width_data;
      // compare each delivered result with the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d", $time, result_kind);
          errors <= errors + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            errors <= errors + 1;
          end
          if (exp_r.last) segments_seen <= segments_seen + 1;
        end
      end
      // predict from each accepted request
      if (point_valid && point_ready)
        extrude_point(first_point, point_x, point_y, point_z);
    end
  end

endmodule

// ===== verif/polyline_box_extruder_test.sv =====
module polyline_box_extruder_test;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 0;
  logic               rst = 1;
  logic               line_width_we = 0;
  logic [31:0]        line_width_data = 0;
  logic               point_valid = 0;
  logic               point_ready;
  logic               first_point = 0;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic               result_valid;
  logic               result_ready = 0;
  logic               result_kind;
  logic signed [31:0] corner_x, corner_y, corner_z;
  logic [14:0]        tri_first, tri_second, tri_third;
  logic [30:0]        half_extent_x, half_extent_y, half_extent_z;
  logic               last_of_segment;
  int                 errors, pending, segments_seen;
  int                 idle_cycles;
  int                 requests_sent;
  int                 gap_next;

  always #6 clk = ~clk;

  polyline_box_extruder dut (.*);
  polyline_box_checker chk (.*);

  // Random backpressure on the result side
  initial begin
    int w;
    do @(posedge clk); while (rst);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        result_ready <= 0;
        repeat (w) @(posedge clk);
      end
      result_ready <= 1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (point_valid && point_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL polyline_box_extruder");
      $finish;
    end
  end

  // Valid drops after a request only when the next one waits
  task automatic send_point(input logic fp, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    repeat (gap_next) @(posedge clk);
    point_valid <= 1;
    first_point <= fp;
    point_x <= x; point_y <= y; point_z <= z;
    do @(posedge clk); while (!point_ready);
    requests_sent++;
    gap_next = $urandom_range(0, 15);
    if (gap_next != 0) point_valid <= 0;
  endtask

  task automatic drain();
    if (gap_next == 0) point_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(input logic [31:0] w);
    drain();
    line_width_we <= 1;
    line_width_data <= w;
    @(posedge clk);
    line_width_we <= 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  initial begin
    requests_sent = 0;
    gap_next = $urandom_range(0, 15);
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default width, axis segments, vertical, zero length, extremes
    send_point(0, 0, 0, 0);
    send_point(0, 32'h0001_0000, 0, 0);
    send_point(0, 32'h0001_0000, 32'h0003_0000, 0);
    send_point(0, 32'h0001_0000, 32'h0003_0000, 0);
    send_point(0, 32'h0001_0000, 32'hffff_0000, 0);
    send_point(0, 0, 0, 32'h0002_0000);
    send_point(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_point(0, 32'hffffffff, 32'h00000001, 32'h55555555);
    send_point(1, 32'haaaaaaaa, 32'h55555555, 32'h0);
    send_point(0, 32'h55555555, 32'haaaaaaaa, 32'hffffffff);
    drain();
    set_width(32'hffffffff);
    send_point(0, 32'h7fffffff, 0, 32'h80000000);
    send_point(0, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_point(0, 32'h0, 32'h0, 32'h0);
    set_width(0);
    send_point(0, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
    send_point(0, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
    set_width(32'h0000_8000);

    // Random polylines, coordinates half small, half extreme or random
    for (int n = 0; n < 200; n++) begin
      if (n == 100) set_width($urandom_range(1, 32'h0004_0000));
      if (n == 160) set_width($urandom);
      if (n == 60) drain();
      send_point($urandom_range(0, 9) == 0, rand_coord(), rand_coord(), rand_coord());
    end

    // Restarts at unit width
    set_width(32'h0001_0000);
    send_point(1, 0, 0, 0);
    send_point(1, 32'h0002_0000, 0, 0);
    send_point(0, 32'h0002_0000, 32'h0002_0000, 0);

    drain();
    $display("Sent %0d points; %0d segments checked across widths incl. 0 and max.",
             requests_sent, segments_seen);
    $display("Covered vertical, zero-length, saturating and restart cases.");
    if (errors == 0) begin
      $display("PASS polyline_box_extruder");
    end else begin
      $display("FAIL polyline_box_extruder");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pbe_pkg.sv
rtl/core/pbe_front.sv
rtl/core/pbe_queue.sv
rtl/core/pbe_norm.sv
rtl/core/pbe_back.sv
rtl/core/polyline_box_extruder.sv
verif/polyline_box_checker.sv
verif/polyline_box_extruder_test.sv
